// ===== rtl/hpack_pkg.sv =====
// Package: HPACK static Huffman code table and shared constants.
package hpack_pkg;

    localparam int CODE_W   = 30;
    localparam int LEN_W    = 5;
    localparam int MAX_OUT  = 5;
    localparam int CNT_W    = 3;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [LEN_W-1:0]  len_t;

    localparam logic [CODE_W-1:0] CODE_ROM [256] = '{
        30'h1ff8, 30'h7fffd8, 30'hfffffe2, 30'hfffffe3, 30'hfffffe4, 30'hfffffe5, 30'hfffffe6,
        30'hfffffe7, 30'hfffffe8, 30'hffffea, 30'h3ffffffc, 30'hfffffe9, 30'hfffffea,
        30'h3ffffffd, 30'hfffffeb, 30'hfffffec, 30'hfffffed, 30'hfffffee, 30'hfffffef,
        30'hffffff0, 30'hffffff1, 30'hffffff2, 30'h3ffffffe, 30'hffffff3, 30'hffffff4,
        30'hffffff5, 30'hffffff6, 30'hffffff7, 30'hffffff8, 30'hffffff9, 30'hffffffa,
        30'hffffffb, 30'h14, 30'h3f8, 30'h3f9, 30'hffa, 30'h1ff9, 30'h15, 30'hf8, 30'h7fa,
        30'h3fa, 30'h3fb, 30'hf9, 30'h7fb, 30'hfa, 30'h16, 30'h17, 30'h18,
        30'h0, 30'h1, 30'h2, 30'h19, 30'h1a, 30'h1b, 30'h1c, 30'h1d,
        30'h1e, 30'h1f, 30'h5c, 30'hfb, 30'h7ffc, 30'h20, 30'hffb, 30'h3fc,
        30'h1ffa, 30'h21, 30'h5d, 30'h5e, 30'h5f, 30'h60, 30'h61, 30'h62,
        30'h63, 30'h64, 30'h65, 30'h66, 30'h67, 30'h68, 30'h69, 30'h6a,
        30'h6b, 30'h6c, 30'h6d, 30'h6e, 30'h6f, 30'h70, 30'h71, 30'h72,
        30'hfc, 30'h73, 30'hfd, 30'h1ffb, 30'h7fff0, 30'h1ffc, 30'h3ffc, 30'h22,
        30'h7ffd, 30'h3, 30'h23, 30'h4, 30'h24, 30'h5, 30'h25, 30'h26,
        30'h27, 30'h6, 30'h74, 30'h75, 30'h28, 30'h29, 30'h2a, 30'h7,
        30'h2b, 30'h76, 30'h2c, 30'h8, 30'h9, 30'h2d, 30'h77, 30'h78,
        30'h79, 30'h7a, 30'h7b, 30'h7ffe, 30'h7fc, 30'h3ffd, 30'h1ffd, 30'hffffffc,
        30'hfffe6, 30'h3fffd2, 30'hfffe7, 30'hfffe8, 30'h3fffd3, 30'h3fffd4, 30'h3fffd5,
        30'h7fffd9, 30'h3fffd6, 30'h7fffda, 30'h7fffdb, 30'h7fffdc, 30'h7fffdd, 30'h7fffde,
        30'hffffeb, 30'h7fffdf, 30'hffffec, 30'hffffed, 30'h3fffd7, 30'h7fffe0, 30'hffffee,
        30'h7fffe1, 30'h7fffe2, 30'h7fffe3, 30'h7fffe4, 30'h1fffdc, 30'h3fffd8, 30'h7fffe5,
        30'h3fffd9, 30'h7fffe6, 30'h7fffe7, 30'hffffef, 30'h3fffda, 30'h1fffdd, 30'hfffe9,
        30'h3fffdb, 30'h3fffdc, 30'h7fffe8, 30'h7fffe9, 30'h1fffde, 30'h7fffea, 30'h3fffdd,
        30'h3fffde, 30'hfffff0, 30'h1fffdf, 30'h3fffdf, 30'h7fffeb, 30'h7fffec, 30'h1fffe0,
        30'h1fffe1, 30'h3fffe0, 30'h1fffe2, 30'h7fffed, 30'h3fffe1, 30'h7fffee, 30'h7fffef,
        30'hfffea, 30'h3fffe2, 30'h3fffe3, 30'h3fffe4, 30'h7ffff0, 30'h3fffe5, 30'h3fffe6,
        30'h7ffff1, 30'h3ffffe0, 30'h3ffffe1, 30'hfffeb, 30'h7fff1, 30'h3fffe7, 30'h7ffff2,
        30'h3fffe8, 30'h1ffffec, 30'h3ffffe2, 30'h3ffffe3, 30'h3ffffe4, 30'h7ffffde,
        30'h7ffffdf, 30'h3ffffe5, 30'hfffff1, 30'h1ffffed, 30'h7fff2, 30'h1fffe3, 30'h3ffffe6,
        30'h7ffffe0, 30'h7ffffe1, 30'h3ffffe7, 30'h7ffffe2, 30'hfffff2, 30'h1fffe4, 30'h1fffe5,
        30'h3ffffe8, 30'h3ffffe9, 30'hffffffd, 30'h7ffffe3, 30'h7ffffe4, 30'h7ffffe5,
        30'hfffec, 30'hfffff3, 30'hfffed, 30'h1fffe6, 30'h3fffe9, 30'h1fffe7, 30'h1fffe8,
        30'h7ffff3, 30'h3fffea, 30'h3fffeb, 30'h1ffffee, 30'h1ffffef, 30'hfffff4, 30'hfffff5,
        30'h3ffffea, 30'h7ffff4, 30'h3ffffeb, 30'h7ffffe6, 30'h3ffffec, 30'h3ffffed,
        30'h7ffffe7, 30'h7ffffe8, 30'h7ffffe9, 30'h7ffffea, 30'h7ffffeb, 30'hffffffe,
        30'h7ffffec, 30'h7ffffed, 30'h7ffffee, 30'h7ffffef, 30'h7fffff0, 30'h3ffffee
    };

    localparam logic [LEN_W-1:0] LEN_ROM [256] = '{
        13, 23, 28, 28, 28, 28, 28, 28, 28, 24, 30, 28, 28, 30, 28, 28,
        28, 28, 28, 28, 28, 28, 30, 28, 28, 28, 28, 28, 28, 28, 28, 28,
        6, 10, 10, 12, 13, 6, 8, 11, 10, 10, 8, 11, 8, 6, 6, 6,
        5, 5, 5, 6, 6, 6, 6, 6, 6, 6, 7, 8, 15, 6, 12, 10,
        13, 6, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7,
        7, 7, 7, 7, 7, 7, 7, 7, 8, 7, 8, 13, 19, 13, 14, 6,
        15, 5, 6, 5, 6, 5, 6, 6, 6, 5, 7, 7, 6, 6, 6, 5,
        6, 7, 6, 5, 5, 6, 7, 7, 7, 7, 7, 15, 11, 14, 13, 28,
        20, 22, 20, 20, 22, 22, 22, 23, 22, 23, 23, 23, 23, 23, 24, 23,
        24, 24, 22, 23, 24, 23, 23, 23, 23, 21, 22, 23, 22, 23, 23, 24,
        22, 21, 20, 22, 22, 23, 23, 21, 23, 22, 22, 24, 21, 22, 23, 23,
        21, 21, 22, 21, 23, 22, 23, 23, 20, 22, 22, 22, 23, 22, 22, 23,
        26, 26, 20, 19, 22, 23, 22, 25, 26, 26, 26, 27, 27, 26, 24, 25,
        19, 21, 26, 27, 27, 26, 27, 24, 21, 21, 26, 26, 28, 27, 27, 27,
        20, 24, 20, 21, 22, 21, 21, 23, 22, 22, 25, 25, 24, 24, 26, 23,
        26, 27, 26, 26, 27, 27, 27, 27, 27, 28, 27, 27, 27, 27, 27, 26
    };

endpackage

// ===== rtl/hpack_huffman_encoder_top.sv =====
// HPACK static Huffman encoder: one octet in per item, packed code bytes out.
// An accepted octet is looked up in the code ROM and merged with the pending
// bits into a registered 40-bit run register; the run is then drained one
// byte per cycle while m_ready is high. An item yields none or 1 to 5 bytes
// (a 30-bit code on 7 pending bits fills four bytes and a flush adds a fifth).
// A new item is taken in the cycle the previous run's last byte is taken,
// and at once after an item that yields none.
// A string end with bits pending emits the partial byte padded with ones.
module hpack_huffman_encoder_top
    import hpack_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_symbol,
    input  logic       s_string_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_coded_byte,
    output logic       m_last_of_run,
    output logic       m_ends_string
);

    localparam int RUN_W = 8 * MAX_OUT;

    logic [RUN_W-1:0] run_reg, run_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             end_reg, end_next;
    logic [7:0]       pend_reg, pend_next;
    logic [2:0]       pos_reg, pos_next;

    code_t            code;
    len_t             len;
    logic [3:0]       used;
    logic [5:0]       total;
    logic [RUN_W-1:0] bits;
    logic [2:0]       nfull;
    logic [CNT_W-1:0] nout;
    logic [2:0]       rem;
    logic             take;
    logic             last_byte;

    assign last_byte = (cnt_reg == CNT_W'(1));
    assign m_valid   = (cnt_reg != '0);
    assign s_ready   = !m_valid || (m_ready && last_byte);
    assign take      = s_valid && s_ready;

    assign m_coded_byte  = run_reg[RUN_W-1 -: 8];
    assign m_last_of_run = last_byte;
    assign m_ends_string = last_byte && end_reg;

    always_comb begin
        code  = CODE_ROM[s_symbol];
        len   = LEN_ROM[s_symbol];
        used  = 4'd7 - {1'b0, pos_reg};
        total = 6'(used) + 6'(len);
        bits  = {pend_reg, {(RUN_W-8){1'b1}}};
        bits  = bits & ~(RUN_W'(~{2'b11, code} & ((64'(1) << len) - 64'(1))) << (RUN_W - 6'(total)));
        bits  = bits | (RUN_W'({2'b00, code}) << (RUN_W - 6'(total)));
        bits  = bits | ((RUN_W'(1) << (RUN_W - 6'(total))) - RUN_W'(1));
        nfull = total[5:3];
        rem   = total[2:0];
        nout  = CNT_W'(nfull) + CNT_W'(s_string_end && (rem != 3'd0));
    end

    always_comb begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        end_next  = end_reg;
        pend_next = pend_reg;
        pos_next  = pos_reg;
        if (m_valid && m_ready) begin
            run_next = {run_reg[RUN_W-9:0], 8'hFF};
            cnt_next = cnt_reg - CNT_W'(1);
        end
        if (take) begin
            run_next = bits;
            cnt_next = nout;
            end_next = s_string_end;
            if (s_string_end) begin
                pend_next = 8'hFF;
                pos_next  = 3'd7;
            end else begin
                pend_next = bits[RUN_W-1 - 8*nfull -: 8];
                pos_next  = 3'd7 - rem;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            end_reg  <= 1'b0;
            pend_reg <= 8'hFF;
            pos_reg  <= 3'd7;
        end else begin
            cnt_reg  <= cnt_next;
            end_reg  <= end_next;
            pend_reg <= pend_next;
            pos_reg  <= pos_next;
        end
        run_reg <= run_next;
    end

`ifndef NO_ASSERTIONS
    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_OUT))
        else $error("run count too large");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while no bytes pending");
    a_end_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && s_string_end) |=> (m_valid && pos_reg == 3'd7))
        else $error("string end did not yield a byte");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the HPACK static Huffman encoder: directed table, random strings, byte checks.
module tb_top;
    import hpack_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 410;

    typedef struct {
        logic [7:0] coded_byte;
        logic       last_of_run;
        logic       ends_string;
    } coded_t;

    typedef struct {
        logic [7:0] symbol;
        logic       string_end;
        logic       has_known;
        logic [7:0] known_byte;
    } stim_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_symbol = '0;
    logic       s_string_end = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_coded_byte;
    logic       m_last_of_run;
    logic       m_ends_string;

    coded_t     expected_bytes[$];
    logic [7:0] pend_byte;
    logic [2:0] free_pos;
    int         errors = 0;
    int         idle_cycles = 0;
    bit         quiet_tail = 1'b0;
    bit         stim_done = 1'b0;

    hpack_huffman_encoder_top u_top (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void encode_symbol(input logic [7:0] sym, input logic last);
        logic [29:0] code;
        int          len;
        int          pos;
        logic [7:0]  acc;
        int          first;
        coded_t      res;
        code  = CODE_ROM[sym];
        len   = LEN_ROM[sym];
        pos   = free_pos;
        acc   = pend_byte;
        first = expected_bytes.size();
        for (int i = len - 1; i >= 0; i--) begin
            if (!code[i]) acc[pos] = 1'b0;
            if (pos == 0) begin
                res = '{acc, 1'b0, 1'b0};
                expected_bytes.push_back(res);
                acc = 8'hFF;
                pos = 7;
            end else begin
                pos--;
            end
        end
        if (last) begin
            if (pos < 7) begin
                res = '{acc, 1'b0, 1'b0};
                expected_bytes.push_back(res);
            end
            acc = 8'hFF;
            pos = 7;
        end
        if (expected_bytes.size() > first) begin
            expected_bytes[$].last_of_run = 1'b1;
            expected_bytes[$].ends_string = last;
        end
        pend_byte = acc;
        free_pos  = pos[2:0];
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte %02h", $time, m_coded_byte);
                errors++;
            end else begin
                coded_t e;
                e = expected_bytes.pop_front();
                if (e.coded_byte !== m_coded_byte) begin
                    $display("%0t: coded_byte exp %02h got %02h", $time, e.coded_byte,
                             m_coded_byte);
                    errors++;
                end
                if (e.last_of_run !== m_last_of_run) begin
                    $display("%0t: last_of_run exp %0b got %0b", $time, e.last_of_run,
                             m_last_of_run);
                    errors++;
                end
                if (e.ends_string !== m_ends_string) begin
                    $display("%0t: ends_string exp %0b got %0b", $time, e.ends_string,
                             m_ends_string);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (quiet_tail || $urandom_range(0, 3) != 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [7:0] sym, input logic last, input bit may_idle);
        if (may_idle && !quiet_tail && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_symbol     <= sym;
        s_string_end <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        encode_symbol(sym, last);
    endtask

    stim_row_t directed[] = '{
        '{8'd48,  1'b1, 1'b1, 8'h07},
        '{8'd0,   1'b1, 1'b1, 8'hC7},
        '{8'd255, 1'b1, 1'b0, 8'h00},
        '{8'd10,  1'b1, 1'b0, 8'h00},
        '{8'd48,  1'b0, 1'b0, 8'h00},
        '{8'd48,  1'b0, 1'b0, 8'h00},
        '{8'd49,  1'b0, 1'b0, 8'h00},
        '{8'd50,  1'b1, 1'b0, 8'h00},
        '{8'd97,  1'b0, 1'b0, 8'h00},
        '{8'd101, 1'b0, 1'b0, 8'h00},
        '{8'd22,  1'b0, 1'b0, 8'h00},
        '{8'd13,  1'b1, 1'b0, 8'h00},
        '{8'd38,  1'b1, 1'b1, 8'hF8},
        '{8'd127, 1'b0, 1'b0, 8'h00},
        '{8'd128, 1'b0, 1'b0, 8'h00},
        '{8'd170, 1'b0, 1'b0, 8'h00},
        '{8'd85,  1'b0, 1'b0, 8'h00},
        '{8'd1,   1'b1, 1'b0, 8'h00}
    };

    initial begin
        int len;
        int sent;
        pend_byte = 8'hFF;
        free_pos  = 3'd7;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[i]) begin
            send_item(directed[i].symbol, directed[i].string_end, 1'b1);
            if (directed[i].has_known && expected_bytes[$].coded_byte !== directed[i].known_byte)
            begin
                $display("%0t: table byte exp %02h got %02h", $time, directed[i].known_byte,
                         expected_bytes[$].coded_byte);
                errors++;
            end
        end
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
                logic [7:0] sym;
                sym = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(32, 126));
                if (sent > RANDOM_ITEMS - 60) quiet_tail = 1'b1;
                send_item(sym, (k == len - 1) || ($urandom_range(0, 15) == 0), 1'b1);
                sent++;
            end
        end
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        if (errors == 0 && expected_bytes.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
